>>> src/tseq_pkg.sv
package tseq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam int TIME_W = 17;
    localparam int VISITOR_W = 16;
    localparam int RIDE_W = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_OUT_W = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POP = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic                 op;
        logic [TIME_W-1:0]    event_time;
        logic [VISITOR_W-1:0] visitor_id;
        logic [RIDE_W-1:0]    ride_index;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [TIME_W-1:0]      out_time;
        logic [VISITOR_W-1:0]   out_visitor;
        logic [RIDE_W-1:0]      out_ride;
        logic [COUNT_OUT_W-1:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic [TIME_W-1:0]    event_time;
        logic [VISITOR_W-1:0] visitor_id;
        logic [RIDE_W-1:0]    ride_index;
    } entry_t;

    typedef struct packed {
        logic              insert;
        logic              pop;
        logic [TIME_W-1:0] event_time;
    } cell_ctrl_t;

endpackage

>>> src/tseq_cell.sv
module tseq_cell #(
    parameter int COUNT_W = 5,
    parameter int INDEX = 0
) (
    input  logic                clk,
    input  tseq_pkg::cell_ctrl_t ctrl,
    input  tseq_pkg::entry_t    new_entry,
    input  logic [COUNT_W-1:0]  count,
    input  tseq_pkg::entry_t    left_entry,
    input  logic                left_sel,
    input  tseq_pkg::entry_t    right_entry,
    output tseq_pkg::entry_t    entry,
    output logic                sel
);
    import tseq_pkg::*;

    localparam logic [COUNT_W-1:0] MY_INDEX = COUNT_W'(INDEX);

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;

    // A cell is selected when it holds a later time than the new one or lies
    // beyond the stored entries; selection is monotonic along the row.
    assign occupied = MY_INDEX < count;
    assign sel = occupied ? (entry_reg.event_time > ctrl.event_time) : 1'b1;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert && sel)
        begin
            entry_next = left_sel ? left_entry : new_entry;
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> src/time_sorted_event_queue_unit.sv
// Time-sorted event queue built as a row of cells, one entry per cell.
// Requests arrive on req (req_valid/req_stall); op selects insert or pop.
// Every request yields exactly one response on rsp (rsp_valid/rsp_stall)
// carrying a status, the popped entry (zero unless a pop succeeded) and the
// entry count after the request.
// Each cell compares its own time with the new time and shifts by itself, so
// a request is completed in the cycle it is accepted and its response is
// presented from the output register in the following cycle.
// Throughput is one request per cycle while the receiver takes responses.
// When a response is held by rsp_stall, req_stall rises and no further
// transfer is taken until the response register is free again.
// Equal times leave in arrival order. A pop when empty or an insert when
// full is flagged in the status and leaves the queue unchanged.
// Reset empties the queue and clears the response valid; no clearing pass
// is needed, so requests are accepted in the first cycle after reset.
module time_sorted_event_queue_unit #(
    parameter int QUEUE_DEPTH = tseq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  tseq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output tseq_pkg::rsp_t rsp
);
    import tseq_pkg::*;

    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(QUEUE_DEPTH);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               rsp_valid_reg;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    logic       accept;
    logic       is_full;
    logic       is_empty;
    cell_ctrl_t ctrl;
    entry_t     new_entry;
    entry_t     cell_entry [QUEUE_DEPTH];
    logic       cell_sel [QUEUE_DEPTH];
    logic [COUNT_W+COUNT_OUT_W-1:0] count_ext;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept = req_valid && !req_stall;
    assign is_full = count_reg == FULL_COUNT;
    assign is_empty = count_reg == '0;

    assign new_entry.event_time = req.event_time;
    assign new_entry.visitor_id = req.visitor_id;
    assign new_entry.ride_index = req.ride_index;

    assign ctrl.insert = accept && (req.op == OP_INSERT) && !is_full;
    assign ctrl.pop = accept && (req.op == OP_POP) && !is_empty;
    assign ctrl.event_time = req.event_time;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t left_e;
            logic   left_s;
            entry_t right_e;

            if (gi == 0)
            begin : g_first
                assign left_e = new_entry;
                assign left_s = 1'b0;
            end
            else
            begin : g_inner
                assign left_e = cell_entry[gi-1];
                assign left_s = cell_sel[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_e = cell_entry[gi];
            end
            else
            begin : g_body
                assign right_e = cell_entry[gi+1];
            end

            tseq_cell #(
                .COUNT_W(COUNT_W),
                .INDEX(gi)
            ) u_cell (
                .clk(clk),
                .ctrl(ctrl),
                .new_entry(new_entry),
                .count(count_reg),
                .left_entry(left_e),
                .left_sel(left_s),
                .right_entry(right_e),
                .entry(cell_entry[gi]),
                .sel(cell_sel[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.insert)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_next};

    always_comb
    begin
        rsp_next = '0;
        rsp_next.entry_count = count_ext[COUNT_OUT_W-1:0];
        if (req.op == OP_POP)
        begin
            if (is_empty)
            begin
                rsp_next.status = STATUS_EMPTY;
            end
            else
            begin
                rsp_next.status = STATUS_OK;
                rsp_next.out_time = cell_entry[0].event_time;
                rsp_next.out_visitor = cell_entry[0].visitor_id;
                rsp_next.out_ride = cell_entry[0].ride_index;
            end
        end
        else
        begin
            rsp_next.status = is_full ? STATUS_FULL : STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

endmodule
